// File: hdl/tcw_pkg.sv
`timescale 1ns / 1ps
package tcw_pkg;

  // Fixed port widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int BYTE_W = 8;
  localparam int CELL_W = 2 * BYTE_W;

  localparam logic [BYTE_W-1:0] FILL_ATTR  = 8'h07;
  localparam logic [BYTE_W-1:0] ATTR_RESET = 8'h07;
  localparam int                TAB_MASK   = 7;

  localparam logic [BYTE_W-1:0] CH_BS  = 8'd8;
  localparam logic [BYTE_W-1:0] CH_TAB = 8'd9;
  localparam logic [BYTE_W-1:0] CH_NL  = 8'd10;
  localparam logic [BYTE_W-1:0] CH_CR  = 8'd13;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

endpackage

// File: hdl/text_console_writer.sv
`timescale 1ns / 1ps
// Text console writer: keeps a COLUMNS x ROWS screen of char/attribute cells in one
// memory plus a cursor, and runs one command at a time while busy is high. Backspace
// reads the cell, then writes back the cleared attribute. A line feed, wrap or tab off
// the last row scrolls the screen, which walks every cell through the memory's read
// and write ports once. Clear screen sweeps the memory, and after reset the block runs
// the same sweep with busy high before it takes the first command. Each command gives
// one result, shown for a single cycle with out_strobe; the receiver cannot stall it.
// Configuration writes are taken in any cycle.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_op,
  input  logic [tcw_pkg::BYTE_W-1:0] in_char_code,
  input  logic [tcw_pkg::COL_W-1:0]  in_col,
  input  logic [tcw_pkg::ROW_W-1:0]  in_row,
  input  logic                       cfg_we,
  input  logic [tcw_pkg::BYTE_W-1:0] cfg_wdata,
  output logic                       out_strobe,
  output logic [tcw_pkg::COL_W-1:0]  out_cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]  out_cursor_row,
  output logic [tcw_pkg::BYTE_W-1:0] out_cell_char,
  output logic [tcw_pkg::BYTE_W-1:0] out_cell_attr
);

  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_BS,
    S_READ,
    S_PRIME,
    S_SCROLL,
    S_FINISH
  } state_t;

  state_t              state_r, state_nxt;
  logic [CW-1:0]       col_r, col_nxt;
  logic [RW-1:0]       row_r, row_nxt;
  logic [BYTE_W-1:0]   attr_r, attr_nxt;
  logic [AW-1:0]       sweep_r, sweep_nxt;
  logic                report_r, report_nxt;
  logic                strobe_r, strobe_nxt;
  logic [COL_W-1:0]    ocol_r, ocol_nxt;
  logic [ROW_W-1:0]    orow_r, orow_nxt;
  logic [BYTE_W-1:0]   ochar_r, ochar_nxt;
  logic [BYTE_W-1:0]   oattr_r, oattr_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [CELL_W-1:0]   ram_rdata;

  logic [AW-1:0]       cur_idx;
  logic [AW-1:0]       rd_idx;
  logic [CW-1:0]       sat_col;
  logic [RW-1:0]       sat_row;
  logic [CW:0]         col_inc;
  logic [CW:0]         col_tab;
  logic [AW:0]         scroll_rd;
  logic                line_inc;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cur_idx   = AW'(32'(row_r) * COLUMNS + 32'(col_r));
  assign sat_col   = (32'(in_col) > COLUMNS - 1) ? CW'(COLUMNS - 1) : CW'(in_col);
  assign sat_row   = (32'(in_row) > ROWS - 1) ? RW'(ROWS - 1) : RW'(in_row);
  assign rd_idx    = AW'(32'(sat_row) * COLUMNS + 32'(sat_col));
  assign col_inc   = {1'b0, col_r} + (CW+1)'(1);
  assign col_tab   = ({1'b0, col_r} | (CW+1)'(TAB_MASK)) + (CW+1)'(1);
  assign scroll_rd = (AW+1)'(32'(sweep_r) + 1 + COLUMNS);

  always_comb begin
    state_nxt  = state_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    attr_nxt   = cfg_we ? cfg_wdata : attr_r;
    sweep_nxt  = sweep_r;
    report_nxt = report_r;
    strobe_nxt = 1'b0;
    ocol_nxt   = ocol_r;
    orow_nxt   = orow_r;
    ochar_nxt  = '0;
    oattr_nxt  = '0;
    ram_we     = 1'b0;
    ram_waddr  = cur_idx;
    ram_wdata  = '0;
    ram_raddr  = cur_idx;
    line_inc   = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_r;
        if (32'(sweep_r) == CELLS - 1) begin
          state_nxt  = S_IDLE;
          strobe_nxt = report_r;
          report_nxt = 1'b0;
        end else begin
          sweep_nxt = sweep_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_FINISH;
          unique case (op_t'(in_op))
            OP_PUT: begin
              priority if (in_char_code == CH_NL) begin
                col_nxt  = '0;
                line_inc = 1'b1;
              end else if (in_char_code == CH_BS) begin
                // read the cell, clear its attribute next cycle
                if (col_r != '0) state_nxt = S_BS;
              end else if (in_char_code == CH_TAB) begin
                if (32'(col_tab) > COLUMNS - 1) begin
                  col_nxt  = '0;
                  line_inc = 1'b1;
                end else begin
                  col_nxt = CW'(col_tab);
                end
              end else if (in_char_code == CH_CR) begin
                col_nxt = '0;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = {attr_r, in_char_code};
                if (32'(col_inc) > COLUMNS - 1) begin
                  col_nxt  = '0;
                  line_inc = 1'b1;
                end else begin
                  col_nxt = CW'(col_inc);
                end
              end
              if (line_inc) begin
                if (32'(row_r) == ROWS - 1) begin
                  state_nxt = S_PRIME;
                  sweep_nxt = '0;
                end else begin
                  row_nxt = row_r + RW'(1);
                end
              end
            end
            OP_SET: begin
              col_nxt = sat_col;
              row_nxt = sat_row;
            end
            OP_CLEAR: begin
              col_nxt    = '0;
              row_nxt    = '0;
              sweep_nxt  = '0;
              report_nxt = 1'b1;
              state_nxt  = S_CLEAR;
            end
            OP_READ: begin
              ram_raddr = rd_idx;
              state_nxt = S_READ;
            end
          endcase
        end
      end
      S_BS: begin
        ram_we     = 1'b1;
        ram_wdata  = {8'h00, ram_rdata[BYTE_W-1:0]};
        col_nxt    = col_r - CW'(1);
        state_nxt  = S_FINISH;
      end
      S_READ: begin
        strobe_nxt = 1'b1;
        ochar_nxt  = ram_rdata[BYTE_W-1:0];
        oattr_nxt  = ram_rdata[CELL_W-1:BYTE_W];
        state_nxt  = S_IDLE;
      end
      S_PRIME: begin
        ram_raddr = AW'(COLUMNS);
        state_nxt = S_SCROLL;
      end
      S_SCROLL: begin
        // write cell sweep_r from the row below, read one cell ahead
        ram_we    = 1'b1;
        ram_waddr = sweep_r;
        ram_wdata = (32'(sweep_r) < CELLS - COLUMNS) ? ram_rdata : {FILL_ATTR, 8'h00};
        ram_raddr = (32'(scroll_rd) < CELLS) ? AW'(scroll_rd) : '0;
        if (32'(sweep_r) == CELLS - 1) begin
          strobe_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          sweep_nxt = sweep_r + AW'(1);
        end
      end
      S_FINISH: begin
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (strobe_nxt) begin
      ocol_nxt = COL_W'(col_nxt);
      orow_nxt = ROW_W'(row_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      col_r    <= '0;
      row_r    <= '0;
      attr_r   <= ATTR_RESET;
      sweep_r  <= '0;
      report_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      attr_r   <= attr_nxt;
      sweep_r  <= sweep_nxt;
      report_r <= report_nxt;
      strobe_r <= strobe_nxt;
    end
    ocol_r  <= ocol_nxt;
    orow_r  <= orow_nxt;
    ochar_r <= ochar_nxt;
    oattr_r <= oattr_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_strobe     = strobe_r;
  assign out_cursor_col = ocol_r;
  assign out_cursor_row = orow_r;
  assign out_cell_char  = ochar_r;
  assign out_cell_attr  = oattr_r;

endmodule

// File: hdl/tcw_ram.sv
`timescale 1ns / 1ps
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/tcw_checker.sv
`timescale 1ns / 1ps
module tcw_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_strobe,
  input logic [tcw_pkg::COL_W-1:0] out_cursor_col,
  input logic [tcw_pkg::ROW_W-1:0] out_cursor_row
);

  // an accepted item always raises busy in the following cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while busy");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without preceding work");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (32'(out_cursor_col) < COLUMNS && 32'(out_cursor_row) < ROWS))
    else $error("cursor outside the screen");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_strobe     (out_strobe),
  .out_cursor_col (out_cursor_col),
  .out_cursor_row (out_cursor_row)
);

// File: test/text_console_writer_tb.sv
`timescale 1ns / 1ps
module text_console_writer_tb;
  import tcw_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int COLUMNS     = 80;
  localparam int ROWS        = 25;
  localparam int CELLS       = COLUMNS * ROWS;
  localparam int CYCLE_LIMIT = 12_000_000;
  localparam int PRINT_CAP   = 40;

  typedef struct packed {
    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [BYTE_W-1:0] cell_char;
    logic [BYTE_W-1:0] cell_attr;
  } echo_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  op_t  cmd_op;
  logic [BYTE_W-1:0] cmd_char;
  logic [COL_W-1:0]  cmd_col;
  logic [ROW_W-1:0]  cmd_row;
  logic              cfg_we;
  logic [BYTE_W-1:0] cfg_wdata;
  logic              out_strobe;
  logic [COL_W-1:0]  out_cursor_col;
  logic [ROW_W-1:0]  out_cursor_row;
  logic [BYTE_W-1:0] out_cell_char;
  logic [BYTE_W-1:0] out_cell_attr;

  // Shadow copy of the console
  logic [CELL_W-1:0] shadow_cells [CELLS];
  int unsigned       shadow_col;
  int unsigned       shadow_row;
  logic [BYTE_W-1:0] shadow_attr;

  echo_t       echoes_due[$];
  echo_t       echo_front;
  int unsigned mismatches  = 0;
  int unsigned items_sent  = 0;
  int unsigned echoes_seen = 0;
  int unsigned cycle_count = 0;
  bit          no_gaps     = 1'b0;

  text_console_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (cmd_op),
    .in_char_code  (cmd_char),
    .in_col        (cmd_col),
    .in_row        (cmd_row),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_strobe    (out_strobe),
    .out_cursor_col(out_cursor_col),
    .out_cursor_row(out_cursor_row),
    .out_cell_char (out_cell_char),
    .out_cell_attr (out_cell_attr)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic flag_mismatch(string what);
    mismatches++;
    // keep the log short when everything goes wrong
    if (mismatches <= PRINT_CAP)
      $display("%0t mismatch: %s", $realtime, what);
  endtask

  task automatic check_field(string name, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
    if (got !== want)
      flag_mismatch($sformatf("result %0d %s got %0h want %0h", echoes_seen, name, got, want));
  endtask

  // Apply one command to the shadow console and return the result it gives.
  function automatic echo_t advance_screen(op_t op, logic [BYTE_W-1:0] ch,
                                           logic [COL_W-1:0] c, logic [ROW_W-1:0] r);
    echo_t       e;
    int unsigned at;
    int unsigned sc;
    int unsigned sr;
    e  = '0;
    sc = (c > COLUMNS - 1) ? COLUMNS - 1 : c;
    sr = (r > ROWS - 1) ? ROWS - 1 : r;
    case (op)
      OP_PUT: begin
        at = shadow_row * COLUMNS + shadow_col;
        if (ch == CH_NL) begin
          shadow_col = 0;
          shadow_row++;
        end else if (ch == CH_BS) begin
          if (shadow_col != 0) begin
            shadow_cells[at][CELL_W-1:BYTE_W] = '0;
            shadow_col--;
          end
        end else if (ch == CH_TAB) begin
          shadow_col = (shadow_col | TAB_MASK) + 1;
          if (shadow_col > COLUMNS - 1) begin
            shadow_col = 0;
            shadow_row++;
          end
        end else if (ch == CH_CR) begin
          shadow_col = 0;
        end else begin
          shadow_cells[at] = {shadow_attr, ch};
          shadow_col++;
          if (shadow_col > COLUMNS - 1) begin
            shadow_col = 0;
            shadow_row++;
          end
        end
        // scroll up one row and blank the bottom row
        if (shadow_row > ROWS - 1) begin
          for (int i = 0; i < CELLS; i++)
            shadow_cells[i] = (i + COLUMNS < CELLS) ? shadow_cells[i + COLUMNS]
                                                    : {FILL_ATTR, 8'h00};
          shadow_row = ROWS - 1;
        end
      end
      OP_SET: begin
        shadow_col = sc;
        shadow_row = sr;
      end
      OP_CLEAR: begin
        foreach (shadow_cells[i]) shadow_cells[i] = '0;
        shadow_col = 0;
        shadow_row = 0;
      end
      default: begin
        at          = sr * COLUMNS + sc;
        e.cell_char = shadow_cells[at][BYTE_W-1:0];
        e.cell_attr = shadow_cells[at][CELL_W-1:BYTE_W];
      end
    endcase
    e.cur_col = shadow_col[COL_W-1:0];
    e.cur_row = shadow_row[ROW_W-1:0];
    return e;
  endfunction

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (echoes_due.size() == 0) begin
        flag_mismatch($sformatf("result with nothing due: col %0d row %0d",
                                out_cursor_col, out_cursor_row));
      end else begin
        echo_front = echoes_due.pop_front();
        check_field("cursor_col", out_cursor_col, echo_front.cur_col);
        check_field("cursor_row", out_cursor_row, echo_front.cur_row);
        check_field("cell_char", out_cell_char, echo_front.cell_char);
        check_field("cell_attr", out_cell_attr, echo_front.cell_attr);
      end
      echoes_seen++;
    end
  end

  // Drive one item and hold it until the block takes it; start stays high on return.
  task automatic issue_command(op_t op, logic [BYTE_W-1:0] ch,
                               logic [COL_W-1:0] c, logic [ROW_W-1:0] r);
    while (!no_gaps && $urandom_range(0, 99) < 23) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    cmd_op   <= op;
    cmd_char <= ch;
    cmd_col  <= c;
    cmd_row  <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    echoes_due.push_back(advance_screen(op, ch, c, r));
    items_sent++;
  endtask

  task automatic set_text_attr(logic [BYTE_W-1:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (echoes_due.size() != 0 || busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    shadow_attr = value;
  endtask

  function automatic logic [COL_W-1:0] rand_col();
    if ($urandom_range(0, 99) < 85) return COL_W'($urandom_range(0, COLUMNS - 1));
    return COL_W'($urandom_range(COLUMNS, (1 << COL_W) - 1));
  endfunction

  function automatic logic [ROW_W-1:0] rand_row();
    if ($urandom_range(0, 99) < 85) return ROW_W'($urandom_range(0, ROWS - 1));
    return ROW_W'($urandom_range(ROWS, (1 << ROW_W) - 1));
  endfunction

  function automatic logic [BYTE_W-1:0] rand_text_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) return CH_NL;
    if (pick < 6) return CH_TAB;
    if (pick < 9) return CH_BS;
    if (pick < 11) return CH_CR;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic test_plain_text();
    issue_command(OP_PUT, 8'h41, '0, '0);
    issue_command(OP_PUT, 8'hFF, '0, '0);
    issue_command(OP_PUT, 8'h00, '0, '0);
    issue_command(OP_READ, 8'h00, 7'd0, 5'd0);
  endtask

  task automatic test_control_bytes();
    set_text_attr(8'hFF);
    issue_command(OP_PUT, CH_TAB, '0, '0);
    issue_command(OP_PUT, CH_CR, '0, '0);
    // backspace at column 0 leaves everything alone
    issue_command(OP_PUT, CH_BS, '0, '0);
    issue_command(OP_SET, 8'h00, 7'd1, 5'd0);
    issue_command(OP_PUT, CH_BS, '0, '0);
    issue_command(OP_READ, 8'h00, 7'd1, 5'd0);
    issue_command(OP_PUT, CH_NL, '0, '0);
  endtask

  task automatic test_cursor_limits();
    set_text_attr(8'h00);
    issue_command(OP_SET, 8'h00, 7'd127, 5'd31);
    issue_command(OP_READ, 8'h00, 7'd127, 5'd31);
    issue_command(OP_SET, 8'h00, 7'd79, 5'd0);
    issue_command(OP_PUT, 8'h78, '0, '0);
    // tab from column 75 runs off the row
    issue_command(OP_SET, 8'h00, 7'd75, 5'd2);
    issue_command(OP_PUT, CH_TAB, '0, '0);
  endtask

  task automatic test_scroll();
    set_text_attr(8'h80);
    issue_command(OP_SET, 8'h00, 7'd0, 5'd24);
    issue_command(OP_PUT, 8'h7A, '0, '0);
    issue_command(OP_PUT, CH_NL, '0, '0);
    issue_command(OP_READ, 8'h00, 7'd0, 5'd23);
    issue_command(OP_READ, 8'h00, 7'd5, 5'd24);
    issue_command(OP_SET, 8'h00, 7'd76, 5'd24);
    issue_command(OP_PUT, CH_TAB, '0, '0);
  endtask

  task automatic test_clear();
    issue_command(OP_CLEAR, 8'h00, '0, '0);
    issue_command(OP_READ, 8'h00, 7'd0, 5'd0);
  endtask

  // Mostly runs of text with cursor moves and read-backs, plus a little noise.
  task automatic test_random_session(int unsigned count, logic [BYTE_W-1:0] attr, bit steady);
    int unsigned stop_at;
    int          pick;
    int          len;
    set_text_attr(attr);
    no_gaps = steady;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        len = $urandom_range(1, 24);
        repeat (len) issue_command(OP_PUT, rand_text_byte(), rand_col(), rand_row());
      end else if (pick < 65) begin
        issue_command(OP_SET, BYTE_W'($urandom), rand_col(), rand_row());
      end else if (pick < 97) begin
        len = $urandom_range(1, 3);
        repeat (len) begin
          // read back the cell just left behind, or any cell
          if ($urandom_range(0, 1))
            issue_command(OP_READ, BYTE_W'($urandom),
                          COL_W'(shadow_col == 0 ? 0 : shadow_col - 1),
                          ROW_W'(shadow_row));
          else
            issue_command(OP_READ, BYTE_W'($urandom), rand_col(), rand_row());
        end
      end else if (pick < 98) begin
        issue_command(OP_CLEAR, BYTE_W'($urandom), rand_col(), rand_row());
      end else begin
        issue_command(op_t'($urandom_range(0, 3)), BYTE_W'($urandom), rand_col(), rand_row());
      end
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    cmd_op    <= OP_PUT;
    cmd_char  <= '0;
    cmd_col   <= '0;
    cmd_row   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    foreach (shadow_cells[i]) shadow_cells[i] = '0;
    shadow_col  = 0;
    shadow_row  = 0;
    shadow_attr = ATTR_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_plain_text();
    test_control_bytes();
    test_cursor_limits();
    test_scroll();
    test_clear();
    test_random_session(475, 8'hFF, 1'b0);
    test_random_session(475, 8'h00, 1'b1);
    test_random_session(475, BYTE_W'($urandom_range(0, 255)), 1'b0);
    test_random_session(475, ATTR_RESET, 1'b0);

    start <= 1'b0;
    while (echoes_due.size() != 0) @(posedge clk);
    // a stray result could still follow a scroll
    repeat (CELLS + 8) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
